// ===== src/pcpm_pkg.sv =====
// shared types, constants and defaults for the pot to clock period mapper
package pcpm_pkg;

  // default build parameters
  localparam int OVERSAMPLE_DEF = 16;
  localparam int ADC_BITS_DEF   = 12;

  // fixed field widths
  localparam int SAMPLE_W    = 12;
  localparam int FREQ_W      = 16;
  localparam int TIME_W      = 27;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int WEIGHT_W    = 9;
  localparam int DZ_W        = 10;

  // microseconds per second times 100, numerator of the period
  localparam logic [TIME_W-1:0] PERIOD_NUM = 27'd100_000_000;

  // full weight, the new average replaces the old one
  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;

  // register indexes on the config port
  localparam logic [CFG_INDEX_W-1:0] REG_EMA_WEIGHT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_END_DZ      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_FREQ    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_FREQ    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HYSTERESIS  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_HIGH    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_LOW     = 3'd6;

  // register reset values
  localparam logic [WEIGHT_W-1:0] RST_EMA_WEIGHT = 9'd51;
  localparam logic [DZ_W-1:0]     RST_END_DZ     = 10'd40;
  localparam logic [FREQ_W-1:0]   RST_MIN_FREQ   = 16'd100;
  localparam logic [FREQ_W-1:0]   RST_MAX_FREQ   = 16'd10000;
  localparam logic [FREQ_W-1:0]   RST_HYSTERESIS = 16'd20;
  localparam logic [FREQ_W-1:0]   RST_MIN_HIGH   = 16'd100;
  localparam logic [FREQ_W-1:0]   RST_MIN_LOW    = 16'd2;

  // sample mode codes
  localparam logic MODE_SEED = 1'b0;
  localparam logic MODE_ACC  = 1'b1;

  // input beat
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                mode;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic [FREQ_W-1:0] freq_centi;
    logic [TIME_W-1:0] cycle_us;
    logic [TIME_W-1:0] high_time_us;
    logic [TIME_W-1:0] low_time_us;
  } out_beat_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG_GO,
    ST_EMA_MUL,
    ST_EMA_ADD,
    ST_MAP_PREP,
    ST_MAP_MUL,
    ST_MAP_GO,
    ST_MAP_WAIT,
    ST_DECIDE,
    ST_PER_GO,
    ST_PER_WAIT,
    ST_HIGH,
    ST_LOW_MUL,
    ST_PUBLISH
  } state_t;

endpackage

// ===== src/pcpm_stream_if.sv =====
// valid/ready stream channel carrying one beat type
interface pcpm_stream_if #(
  parameter type beat_t = logic
);
  logic  valid;
  logic  ready;
  beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/pot_to_clock_period_mapper_unit.sv =====
// pot to clock period mapper: ema smoothing, deadzone mapping, hysteresis, period split
//
// Each sample beat is taken while the sequencer is idle. A seed beat (mode 0) loads the
// average. Every OVERSAMPLE-th accumulating beat then runs a sequencer: the group average
// by a constant reciprocal multiply, the ema step, and over one shared restoring divider of
// ADC_BITS+25 bits, one quotient bit per cycle, the rounded frequency mapping and, when a
// new frequency is adopted, the period. After that beat din.ready stays low until the
// sequencer is back in idle. Results wait in an output register, so a stalled consumer only
// holds the sequencer at its last step. Config registers are written by the user only while
// the block is idle; the block itself does not enforce it.
module pot_to_clock_period_mapper_unit #(
  parameter int OVERSAMPLE = pcpm_pkg::OVERSAMPLE_DEF,
  parameter int ADC_BITS   = pcpm_pkg::ADC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  pcpm_stream_if.sink                      din,
  pcpm_stream_if.source                    dout,
  input  logic                             cfg_we,
  input  logic [pcpm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pcpm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pcpm_pkg::*;

  localparam int SMOOTH_W = ADC_BITS + 8;
  localparam int SUM_W    = ADC_BITS + $clog2(OVERSAMPLE);
  localparam int CNT_W    = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
  localparam int NUM_W    = ADC_BITS + 25;
  localparam int DEN_W    = ADC_BITS + 9;
  localparam int PROD_W   = ADC_BITS + 26;
  localparam int DS_W     = ((ADC_BITS > 11) ? ADC_BITS : 11) + 2;
  localparam int CW       = ((SMOOTH_W > 18) ? SMOOTH_W : 18) + 1;
  localparam int MV_W     = ADC_BITS + 8;
  localparam int LP_W     = TIME_W + 1 + FREQ_W;
  localparam int FULL     = (1 << ADC_BITS) - 1;

  // reciprocal of the group size, exact for every group sum times 256
  localparam int AVG_X_W  = SUM_W + 8;
  localparam int AVG_SH   = AVG_X_W + $clog2(OVERSAMPLE);
  localparam int AVG_M_W  = AVG_X_W + 1;
  localparam int AVG_P_W  = SUM_W + AVG_M_W;
  localparam longint AVG_MUL =
    ((longint'(1) << AVG_SH) + longint'(OVERSAMPLE) - 1) / longint'(OVERSAMPLE);

  // config registers
  logic [WEIGHT_W-1:0] ema_weight;
  logic [DZ_W-1:0]     end_deadzone;
  logic [FREQ_W-1:0]   min_freq_centi;
  logic [FREQ_W-1:0]   max_freq_centi;
  logic [FREQ_W-1:0]   hysteresis_centi;
  logic [FREQ_W-1:0]   min_high_us;
  logic [FREQ_W-1:0]   low_floor_us;

  // state
  state_t              state;
  state_t              state_next;
  logic [SUM_W-1:0]    group_sum;
  logic [CNT_W-1:0]    group_count;
  logic [SMOOTH_W-1:0] smoothed;
  logic [FREQ_W-1:0]   stable_freq;
  logic                has_published;
  logic                out_valid;
  out_beat_t           out_beat;

  // working registers
  logic [SMOOTH_W-1:0]        avg;
  logic                       ema_up;
  logic [SMOOTH_W+8:0]        ema_prod;
  logic [MV_W-1:0]            map_num;
  logic [MV_W-1:0]            map_den;
  logic signed [PROD_W-1:0]   map_prod;
  logic [FREQ_W-1:0]          map_q;
  logic [FREQ_W-1:0]          freq;
  logic [TIME_W-1:0]          period;
  logic [TIME_W-1:0]          high;
  logic [LP_W-1:0]            low_prod;

  // combinational
  logic                       accept;
  logic                       last;
  logic [ADC_BITS-1:0]        s;
  logic [SUM_W-1:0]           sum_add;
  logic [AVG_P_W-1:0]         avg_prod;
  logic                       in_ready;
  logic                       out_free;
  logic                       div_start;
  logic [NUM_W-1:0]           div_num;
  logic [DEN_W-1:0]           div_den;
  logic                       div_done;
  logic [NUM_W-1:0]           div_quot;
  logic [WEIGHT_W-1:0]        w_sat;
  logic [SMOOTH_W-1:0]        ema_diff;
  logic [SMOOTH_W-1:0]        ema_step;
  logic signed [DS_W-1:0]     den_raw;
  logic signed [CW-1:0]       num_raw;
  logic [MV_W-1:0]            den_val;
  logic [MV_W-1:0]            num_clamp;
  logic [MV_W-1:0]            den_clamp;
  logic signed [FREQ_W:0]     freq_range;
  logic [PROD_W-1:0]          map_mag;
  logic [FREQ_W:0]            f_sum;
  logic [FREQ_W-1:0]          f_new;
  logic [FREQ_W-1:0]          f_lo;
  logic [FREQ_W-1:0]          f_hi;
  logic                       rail;
  logic [FREQ_W-1:0]          f_diff;
  logic                       adopt;
  logic [FREQ_W-1:0]          fd;
  logic [TIME_W-1:0]          half;
  logic [TIME_W:0]            high_plus;
  logic [TIME_W-1:0]          low_val;

  // handshake terms
  assign accept   = din.valid & din.ready;
  assign out_free = !out_valid || dout.ready;
  assign s        = ADC_BITS'(din.payload.sample);
  assign sum_add  = group_sum + SUM_W'(s);
  assign last     = group_count == CNT_W'(OVERSAMPLE - 1);

  assign din.ready    = in_ready;
  assign dout.valid   = out_valid;
  assign dout.payload = out_beat;

  // group average in q.8 by reciprocal multiply
  assign avg_prod = group_sum * AVG_M_W'(AVG_MUL);

  // ema step terms
  always_comb begin
    w_sat    = (ema_weight > WEIGHT_FULL) ? WEIGHT_FULL : ema_weight;
    ema_diff = (avg >= smoothed) ? (avg - smoothed) : (smoothed - avg);
    ema_step = ema_prod[SMOOTH_W+7:8];
  end

  // trimmed numerator and denominator of the mapping
  always_comb begin
    den_raw = DS_W'(FULL) - DS_W'({end_deadzone, 1'b0});
    num_raw = CW'(smoothed) - CW'({end_deadzone, 8'b0});
    den_val = {den_raw[ADC_BITS-1:0], 8'b0};
    if (den_raw > 0) begin
      den_clamp = den_val;
      if (num_raw < 0) begin
        num_clamp = '0;
      end else if (num_raw > $signed(CW'(den_val))) begin
        num_clamp = den_val;
      end else begin
        num_clamp = num_raw[MV_W-1:0];
      end
    end else begin
      // deadzone covers the whole travel
      den_clamp = MV_W'(1);
      num_clamp = (num_raw > 0) ? MV_W'(1) : '0;
    end
  end

  // signed span and magnitude of the scaled product
  always_comb begin
    freq_range = $signed({1'b0, max_freq_centi}) - $signed({1'b0, min_freq_centi});
    map_mag    = map_prod[PROD_W-1] ? PROD_W'(-map_prod) : PROD_W'(map_prod);
  end

  // adoption decision
  always_comb begin
    if (map_prod[PROD_W-1]) begin
      f_sum = {1'b0, min_freq_centi} - {1'b0, map_q};
    end else begin
      f_sum = {1'b0, min_freq_centi} + {1'b0, map_q};
    end
    f_new  = f_sum[FREQ_W-1:0];
    f_lo   = (min_freq_centi < max_freq_centi) ? min_freq_centi : max_freq_centi;
    f_hi   = (min_freq_centi < max_freq_centi) ? max_freq_centi : min_freq_centi;
    rail   = (f_new <= f_lo) || (f_new >= f_hi);
    f_diff = (f_new >= stable_freq) ? (f_new - stable_freq) : (stable_freq - f_new);
    adopt  = !has_published || (f_diff >= hysteresis_centi) ||
             (rail && (f_new != stable_freq));
  end

  // period split terms
  always_comb begin
    fd        = (freq == '0) ? FREQ_W'(1) : freq;
    half      = {1'b0, period[TIME_W-1:1]};
    high_plus = (TIME_W+1)'(high) + (TIME_W+1)'(low_floor_us);
    low_val   = (LP_W'(PERIOD_NUM) > low_prod) ? (period - high) : TIME_W'(low_floor_us);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (din.payload.mode == MODE_ACC) && last) begin
          state_next = ST_AVG_GO;
        end
      end
      ST_AVG_GO:   state_next = ST_EMA_MUL;
      ST_EMA_MUL:  state_next = ST_EMA_ADD;
      ST_EMA_ADD:  state_next = ST_MAP_PREP;
      ST_MAP_PREP: state_next = ST_MAP_MUL;
      ST_MAP_MUL:  state_next = ST_MAP_GO;
      ST_MAP_GO:   state_next = ST_MAP_WAIT;
      ST_MAP_WAIT: begin
        if (div_done) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE:   state_next = adopt ? ST_PER_GO : ST_IDLE;
      ST_PER_GO:   state_next = ST_PER_WAIT;
      ST_PER_WAIT: begin
        if (div_done) begin
          state_next = ST_HIGH;
        end
      end
      ST_HIGH:     state_next = ST_LOW_MUL;
      ST_LOW_MUL:  state_next = ST_PUBLISH;
      ST_PUBLISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs and divider operands
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_MAP_GO: begin
        // round half away from zero: (2|n| + d) / 2d
        div_start = 1'b1;
        div_num   = NUM_W'({map_mag[PROD_W-3:0], 1'b0}) + NUM_W'(map_den);
        div_den   = DEN_W'({map_den, 1'b0});
      end
      ST_PER_GO: begin
        div_start = 1'b1;
        div_num   = NUM_W'(PERIOD_NUM);
        div_den   = DEN_W'(fd);
      end
      default: begin
        in_ready  = 1'b0;
        div_start = 1'b0;
      end
    endcase
  end

  // shared divider
  pcpm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // control state, config and smoothing state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      ema_weight       <= RST_EMA_WEIGHT;
      end_deadzone     <= RST_END_DZ;
      min_freq_centi   <= RST_MIN_FREQ;
      max_freq_centi   <= RST_MAX_FREQ;
      hysteresis_centi <= RST_HYSTERESIS;
      min_high_us      <= RST_MIN_HIGH;
      low_floor_us     <= RST_MIN_LOW;
      group_sum        <= '0;
      group_count      <= '0;
      smoothed         <= '0;
      stable_freq      <= '0;
      has_published    <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;

      // config writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_EMA_WEIGHT: ema_weight       <= cfg_data[WEIGHT_W-1:0];
          REG_END_DZ:     end_deadzone     <= cfg_data[DZ_W-1:0];
          REG_MIN_FREQ:   min_freq_centi   <= cfg_data;
          REG_MAX_FREQ:   max_freq_centi   <= cfg_data;
          REG_HYSTERESIS: hysteresis_centi <= cfg_data;
          REG_MIN_HIGH:   min_high_us      <= cfg_data;
          REG_MIN_LOW:    low_floor_us     <= cfg_data;
          default: begin
            ema_weight <= ema_weight;
          end
        endcase
      end

      // sample beat: seed or accumulate
      if (accept) begin
        if (din.payload.mode == MODE_SEED) begin
          smoothed      <= {s, 8'b0};
          group_sum     <= '0;
          group_count   <= '0;
          has_published <= 1'b0;
        end else begin
          group_sum   <= sum_add;
          group_count <= last ? '0 : (group_count + CNT_W'(1));
        end
      end

      // group sum is averaged, then restarts
      if (state == ST_AVG_GO) begin
        group_sum <= '0;
      end

      // ema update, step truncated toward zero
      if (state == ST_EMA_ADD) begin
        smoothed <= ema_up ? (smoothed + ema_step) : (smoothed - ema_step);
      end

      // adopt the new frequency
      if ((state == ST_DECIDE) && adopt) begin
        stable_freq   <= f_new;
        has_published <= 1'b1;
      end

      // output register
      if ((state == ST_PUBLISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_AVG_GO) begin
      avg <= avg_prod[AVG_SH-8 +: SMOOTH_W];
    end
    if (state == ST_EMA_MUL) begin
      ema_up   <= avg >= smoothed;
      ema_prod <= ema_diff * w_sat;
    end
    if (state == ST_MAP_PREP) begin
      map_num <= num_clamp;
      map_den <= den_clamp;
    end
    if (state == ST_MAP_MUL) begin
      map_prod <= $signed({1'b0, map_num}) * freq_range;
    end
    if ((state == ST_MAP_WAIT) && div_done) begin
      map_q <= div_quot[FREQ_W-1:0];
    end
    if ((state == ST_DECIDE) && adopt) begin
      freq <= f_new;
    end
    if ((state == ST_PER_WAIT) && div_done) begin
      period <= div_quot[TIME_W-1:0];
    end
    if (state == ST_HIGH) begin
      high <= (half < TIME_W'(min_high_us)) ? TIME_W'(min_high_us) : half;
    end
    if (state == ST_LOW_MUL) begin
      low_prod <= high_plus * fd;
    end
    if ((state == ST_PUBLISH) && out_free) begin
      out_beat.freq_centi   <= freq;
      out_beat.cycle_us     <= period;
      out_beat.high_time_us <= high;
      out_beat.low_time_us  <= low_val;
    end
  end

`ifndef SYNTHESIS
  // divider finishes only while the sequencer waits on it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_MAP_WAIT || state == ST_PER_WAIT))
    else $error("divider done outside a wait state");

  // group counter wraps before reaching the group size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    group_count <= CNT_W'(OVERSAMPLE - 1))
    else $error("group counter out of range");

  // a seed beat restarts the group and the publish history
  a_seed_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && (din.payload.mode == MODE_SEED)) |=>
      (group_count == '0 && group_sum == '0 && !has_published))
    else $error("seed did not restart the group");

  // a published beat carries the adopted frequency
  a_publish_freq: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_PUBLISH) && out_free) |=>
      (out_valid && dout.payload.freq_centi == stable_freq))
    else $error("published frequency differs from adopted one");
`endif
endmodule

// ===== src/pcpm_div.sv =====
// shared restoring divider, one quotient bit per cycle
module pcpm_div #(
  parameter int NUM_W = 37,
  parameter int DEN_W = 21
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             ge;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    ge    = trial >= {1'b0, dvs};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dvs <= den;
    end else if (busy) begin
      if (ge) begin
        rem <= DEN_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

  assign quot = quo;
endmodule
